[rtl/categorical_sampler_macros.svh]
// Assertion macros used by the categorical sampler checker.
`ifndef CATEGORICAL_SAMPLER_MACROS_SVH
`define CATEGORICAL_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("categorical_sampler: assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("categorical_sampler: assertion failed");

`endif

[rtl/cs_pkg.sv]
// Shared constants and types of the categorical sampler.
package cs_pkg;

    localparam int CS_MAX_SYMBOLS = 256;
    localparam int CS_WEIGHT_BITS = 16;

    localparam int IDX_FIELD_W    = 8;
    localparam int WEIGHT_FIELD_W = 16;
    localparam int U_FIELD_W      = 16;
    localparam int SYM_FIELD_W    = 8;
    localparam int CNT_W          = 9;
    localparam int IN_DATA_W      = 40;
    localparam int OUT_DATA_W     = 8;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    // Control part of the sample token moving down the cell row.
    typedef struct packed {
        logic valid;
        logic found;
    } t_tok_ctl;

endpackage

[rtl/cs_cell.sv]
// One cell of the row: holds one weight and advances the sample token.
module cs_cell
    import cs_pkg::*;
#(
    parameter int K           = 0,
    parameter int MAX_SYMBOLS = CS_MAX_SYMBOLS,
    parameter int WEIGHT_BITS = CS_WEIGHT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  logic                   i_wr_en,
    input  logic [IDX_FIELD_W-1:0] i_wr_idx,
    input  logic [WEIGHT_BITS-1:0] i_wr_weight,
    input  logic [$clog2(MAX_SYMBOLS)-1:0] i_last_idx,
    input  t_tok_ctl               i_ctl,
    input  logic [((WEIGHT_BITS > U_FIELD_W) ? WEIGHT_BITS : U_FIELD_W)
                  + $clog2(MAX_SYMBOLS)-1:0] i_sum,
    input  logic [U_FIELD_W-1:0]   i_u,
    input  logic [$clog2(MAX_SYMBOLS)-1:0] i_sym,
    output t_tok_ctl               o_ctl,
    output logic [((WEIGHT_BITS > U_FIELD_W) ? WEIGHT_BITS : U_FIELD_W)
                  + $clog2(MAX_SYMBOLS)-1:0] o_sum,
    output logic [U_FIELD_W-1:0]   o_u,
    output logic [$clog2(MAX_SYMBOLS)-1:0] o_sym
);

    localparam int IDX_W = $clog2(MAX_SYMBOLS);
    localparam int SUM_W = ((WEIGHT_BITS > U_FIELD_W) ? WEIGHT_BITS : U_FIELD_W) + IDX_W;

    logic [WEIGHT_BITS-1:0] r_weight;
    t_tok_ctl               r_ctl, n_ctl;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [U_FIELD_W-1:0]   r_u;
    logic [IDX_W-1:0]       r_sym, n_sym;
    logic [SUM_W-1:0]       sum_add;
    logic                   is_last;
    logic                   hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (int'(i_wr_idx) == K)) begin
            r_weight <= i_wr_weight;
        end
    end

    assign sum_add = i_sum + SUM_W'(r_weight);
    assign is_last = (i_last_idx == IDX_W'(K));
    assign hit     = (sum_add >= SUM_W'(i_u)) || is_last;

    // Add this weight only while the token is still searching; else pass through.
    always_comb begin
        n_ctl = i_ctl;
        n_sum = i_sum;
        n_sym = i_sym;
        if (i_ctl.valid && !i_ctl.found) begin
            n_sum       = sum_add;
            n_ctl.found = hit;
            n_sym       = IDX_W'(K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_advance) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_sum <= n_sum;
            r_u   <= i_u;
            r_sym <= n_sym;
        end
    end

    assign o_ctl = r_ctl;
    assign o_sum = r_sum;
    assign o_u   = r_u;
    assign o_sym = r_sym;

endmodule

[rtl/categorical_sampler.sv]
// Top level of the categorical sampler: input beats, cell row and result register.
//
// A write beat (tuser 0) stores one weight into its cell in the cycle it is
// taken, and the next beat may follow in the next cycle. A sample beat (tuser 1)
// enters a row of MAX_SYMBOLS cells and moves one cell per cycle while the row
// is not held, each cell adding its weight until the running sum reaches the
// uniform value or the last symbol in use is reached. Its result lands in the
// output register as the token leaves the row, and a new beat is taken in the
// cycle after that, so a new sample waits until the last is through the row. A
// result waiting on the output does not block the next beat; only when a second
// result reaches the end of the row before the first is taken does the row hold.
module categorical_sampler
    import cs_pkg::*;
#(
    parameter int MAX_SYMBOLS = CS_MAX_SYMBOLS,
    parameter int WEIGHT_BITS = CS_WEIGHT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CNT_W-1:0]      i_cfg_wr_data,  // symbol_count
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // entry_index, entry_weight, uniform_value
    input  logic                  s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // chosen_symbol
);

    localparam int IDX_W = $clog2(MAX_SYMBOLS);
    localparam int SUM_W = ((WEIGHT_BITS > U_FIELD_W) ? WEIGHT_BITS : U_FIELD_W) + IDX_W;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_symbol_count;
    logic                   r_out_valid;
    logic [SYM_FIELD_W-1:0] r_out_sym;

    logic [IDX_W-1:0]       last_idx;
    logic                   s_accept;
    logic                   wr_en;
    logic                   inject;
    logic                   advance;
    logic                   row_done;
    logic [WEIGHT_BITS+WEIGHT_FIELD_W-1:0] w_ext;
    logic [WEIGHT_BITS-1:0] wr_weight;
    logic [IDX_W+SYM_FIELD_W-1:0] sym_ext;

    t_tok_ctl               tok_ctl [0:MAX_SYMBOLS];
    logic [SUM_W-1:0]       tok_sum [0:MAX_SYMBOLS];
    logic [U_FIELD_W-1:0]   tok_u   [0:MAX_SYMBOLS];
    logic [IDX_W-1:0]       tok_sym [0:MAX_SYMBOLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= CNT_W'(1);
        end else if (i_cfg_wr_en) begin
            r_symbol_count <= i_cfg_wr_data;
        end
    end

    // Clamp the count to 1..MAX_SYMBOLS and form the index of the last symbol.
    always_comb begin
        priority if (r_symbol_count == '0) begin
            last_idx = '0;
        end else if (int'(r_symbol_count) > MAX_SYMBOLS) begin
            last_idx = IDX_W'(MAX_SYMBOLS - 1);
        end else begin
            last_idx = IDX_W'(r_symbol_count - CNT_W'(1));
        end
    end

    assign s_tready = (r_state == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign wr_en    = s_accept && (s_tuser == MODE_WRITE);
    assign inject   = s_accept && (s_tuser == MODE_SAMPLE);

    assign w_ext     = {{WEIGHT_BITS{1'b0}}, s_tdata[23:8]};
    assign wr_weight = w_ext[WEIGHT_BITS-1:0];

    assign row_done = tok_ctl[MAX_SYMBOLS].valid;
    // Hold the row only when a finished token meets a result not yet taken.
    assign advance  = !(row_done && r_out_valid && !m_tready);

    assign tok_ctl[0] = '{valid: inject, found: 1'b0};
    assign tok_sum[0] = '0;
    assign tok_u[0]   = s_tdata[39:24];
    assign tok_sym[0] = '0;

    for (genvar k = 0; k < MAX_SYMBOLS; k++) begin : g_cell
        cs_cell #(
            .K           (k),
            .MAX_SYMBOLS (MAX_SYMBOLS),
            .WEIGHT_BITS (WEIGHT_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_advance   (advance),
            .i_wr_en     (wr_en),
            .i_wr_idx    (s_tdata[7:0]),
            .i_wr_weight (wr_weight),
            .i_last_idx  (last_idx),
            .i_ctl       (tok_ctl[k]),
            .i_sum       (tok_sum[k]),
            .i_u         (tok_u[k]),
            .i_sym       (tok_sym[k]),
            .o_ctl       (tok_ctl[k+1]),
            .o_sum       (tok_sum[k+1]),
            .o_u         (tok_u[k+1]),
            .o_sym       (tok_sym[k+1])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (inject) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (row_done && advance) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign sym_ext = {{SYM_FIELD_W{1'b0}}, tok_sym[MAX_SYMBOLS]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (row_done && advance) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_done && advance) begin
            r_out_sym <= sym_ext[SYM_FIELD_W-1:0];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_sym;

endmodule

[rtl/cs_checker.sv]
// Port-level checks of the categorical sampler, bound to the top level.
`include "categorical_sampler_macros.svh"

module cs_checker
    import cs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tuser,   // mode
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata    // chosen_symbol
);

    logic wr_beat;
    logic smp_beat;

    assign wr_beat  = s_tvalid && s_tready && (s_tuser == MODE_WRITE);
    assign smp_beat = s_tvalid && s_tready && (s_tuser == MODE_SAMPLE);

    // Hold a stalled result.
    `CS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // A sample beat occupies the row; no beat is taken right after it.
    `CS_ASSERT_NEXT(a_sample_busy, smp_beat, !s_tready)
    // A weight write never blocks the input.
    `CS_ASSERT_NEXT(a_write_free, wr_beat, s_tready)
    // A sample taken while no result is waiting leaves m_tvalid low in the cycle after it is taken.
    `CS_ASSERT_NEXT(a_no_early_result, smp_beat && !m_tvalid, !m_tvalid)

endmodule

bind categorical_sampler cs_checker u_cs_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the categorical sampler: weight writes and inverse-CDF draws.
module tb_top;
    import cs_pkg::*;

    localparam int SETTLE_CYCLES = CS_MAX_SYMBOLS + 44;
    localparam int NUM_ITEMS     = 1950;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic                      mode;
        logic [IDX_FIELD_W-1:0]    idx;
        logic [WEIGHT_FIELD_W-1:0] weight;
        logic [U_FIELD_W-1:0]      u;
    } t_request;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]      i_cfg_wr_data = '0;
    logic                  s_tvalid      = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata       = '0;  // entry_index, entry_weight, uniform_value
    logic                  s_tuser       = 1'b0;  // mode
    logic                  m_tvalid;
    logic                  m_tready      = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;  // chosen_symbol

    // Mirror of the block state
    logic [WEIGHT_FIELD_W-1:0] weight_mem [CS_MAX_SYMBOLS];
    logic [CNT_W-1:0]          symbol_count = CNT_W'(1);

    logic [SYM_FIELD_W-1:0] expected_symbols [$];
    t_request               pending_requests [$];
    t_request               cur_req;

    int issued     = 0;
    int taken      = 0;
    int mismatches = 0;
    int send_gap   = 0;
    int recv_gap   = 0;
    int send_calm  = 0;
    int recv_calm  = 0;

    categorical_sampler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Walk the weights in order and pick the first symbol whose running sum reaches u.
    function automatic logic [SYM_FIELD_W-1:0] draw_symbol(logic [U_FIELD_W-1:0] u);
        int          n;
        logic [23:0] acc;
        if (symbol_count == 0)
            n = 1;
        else if (symbol_count > CS_MAX_SYMBOLS)
            n = CS_MAX_SYMBOLS;
        else
            n = symbol_count;
        acc = '0;
        for (int k = 0; k < n; k++) begin
            acc += weight_mem[k];
            if (acc >= u)
                return SYM_FIELD_W'(k);
        end
        return SYM_FIELD_W'(n - 1);
    endfunction

    // Mostly short gaps, a few long ones, and now and then a long calm stretch.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 20) begin
            calm = $urandom_range(50, 300);
            return 0;
        end
        if (r < 500)
            return 0;
        if (r < 850)
            return $urandom_range(1, 3);
        if (r < 970)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int phase_weight(int profile, int n);
        int lim;
        lim = 131072 / n;
        if (lim > 65535)
            lim = 65535;
        case (profile)
            0: return $urandom_range(0, lim);
            1: return $urandom_range(0, 65535);
            2: return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : 0;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic send(logic mode, logic [IDX_FIELD_W-1:0] idx,
                        logic [WEIGHT_FIELD_W-1:0] w, logic [U_FIELD_W-1:0] u);
        t_request r;
        r.mode   = mode;
        r.idx    = idx;
        r.weight = w;
        r.u      = u;
        pending_requests.insert(pending_requests.size(), r);
        issued++;
    endtask

    task automatic write_weight(int idx, int w);
        send(MODE_WRITE, IDX_FIELD_W'(idx), WEIGHT_FIELD_W'(w), U_FIELD_W'($urandom));
    endtask

    task automatic sample(int u);
        send(MODE_SAMPLE, IDX_FIELD_W'($urandom), WEIGHT_FIELD_W'($urandom), U_FIELD_W'(u));
    endtask

    // Hold until every beat is taken and every draw is back, then let the row drain.
    task automatic wait_idle();
        while (!(taken == issued && expected_symbols.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_symbol_count(int v);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CNT_W'(v);
        symbol_count = CNT_W'(v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (cur_req.mode == MODE_WRITE)
                    weight_mem[cur_req.idx] = cur_req.weight;
                else
                    expected_symbols.insert(expected_symbols.size(),
                                            draw_symbol(cur_req.u));
                taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    cur_req = pending_requests.pop_front();
                    s_tdata  <= {cur_req.u, cur_req.weight, cur_req.idx};
                    s_tuser  <= cur_req.mode;
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output backpressure
    always @(posedge i_clk) begin
        if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                recv_gap = pick_gap(recv_calm);
        end
    end

    // Monitor
    always @(posedge i_clk) begin : result_check
        logic [SYM_FIELD_W-1:0] want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_symbols.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: chosen_symbol %0d", m_tdata);
            end else begin
                want = expected_symbols.pop_front();
                if (m_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("chosen_symbol mismatch: expected %0d, got %0d", want, m_tdata);
                end
            end
        end
    end

    initial begin : stimulus
        int n;
        int r;
        int cnt;
        int profile;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole table first so no draw ever walks an unwritten entry
        for (int k = 0; k < CS_MAX_SYMBOLS; k++)
            write_weight(k, $urandom_range(0, 600));

        // One symbol in use: zero weight falls back to symbol 0, zero u hits at once
        write_weight(0, 0);
        write_weight(CS_MAX_SYMBOLS - 1, 16'hFFFF);
        sample(0);
        sample(16'hFFFF);
        write_weight(0, 16'hFFFF);
        sample(16'hFFFF);

        // Full table: walk deep toward the last entry
        set_symbol_count(CS_MAX_SYMBOLS);
        sample(16'hFFFF);
        write_weight(0, 0);
        sample(16'hFFFF);
        sample(0);
        sample(1);
        write_weight(CS_MAX_SYMBOLS - 1, 0);
        sample(16'hFFFF);

        // Zero count acts as one, oversized count saturates
        set_symbol_count(0);
        sample(16'hFFFF);
        sample(0);
        set_symbol_count(511);
        sample(16'hFFFF);
        sample(40000);
        set_symbol_count(CS_MAX_SYMBOLS + 1);
        sample($urandom);

        while (issued < NUM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                cnt = CS_MAX_SYMBOLS;
            else if (r < 14)
                cnt = 1;
            else if (r < 18)
                cnt = 0;
            else if (r < 24)
                cnt = $urandom_range(CS_MAX_SYMBOLS + 1, 511);
            else if (r < 40)
                cnt = $urandom_range(65, CS_MAX_SYMBOLS - 1);
            else
                cnt = $urandom_range(2, 64);
            set_symbol_count(cnt);

            if (cnt == 0)
                n = 1;
            else if (cnt > CS_MAX_SYMBOLS)
                n = CS_MAX_SYMBOLS;
            else
                n = cnt;

            // Fresh distribution for the active entries: always if n <= 64, else by chance
            profile = $urandom_range(0, 3);
            if (n <= 64 || $urandom_range(0, 2) == 0)
                for (int k = 0; k < n; k++)
                    write_weight(k, phase_weight(profile, n));

            repeat ($urandom_range(15, 40)) begin
                if ($urandom_range(0, 9) == 0)
                    write_weight($urandom_range(0, CS_MAX_SYMBOLS - 1), $urandom_range(0, 65535));
                r = $urandom_range(0, 19);
                if (r == 0)
                    sample(0);
                else if (r == 1)
                    sample(16'hFFFF);
                else
                    sample($urandom_range(0, 65535));
            end
        end

        wait_idle();
        if (mismatches == 0 && expected_symbols.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
